// ===== sv/rwr_pkg.sv =====
// Shared types and constants for the random-walk visit ranker.
`timescale 1ns / 1ps
`default_nettype none

package rwr_pkg;

    // Draw and remainder unit geometry.
    localparam int DRAW_W     = 16;
    localparam int DIV_W      = 17;
    localparam int MOD_STEPS  = 4;
    localparam int MOD_CYCLES = DRAW_W / MOD_STEPS;
    localparam int MOD_CW     = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

    // Field widths fixed by the interface.
    localparam int NODE_W  = 10;
    localparam int COIN_W  = 7;
    localparam int CNT_W   = 32;
    localparam int RANK_W  = 11;
    localparam int NUMN_W  = 11;
    localparam int DAMP_W  = 7;
    localparam int SHOWN_RANKS = 5;

    typedef enum logic [1:0] {
        OP_ADD_EDGE = 2'd0,
        OP_START    = 2'd1,
        OP_STEP     = 2'd2,
        OP_QUERY    = 2'd3
    } t_opcode;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic REG_NUM_NODES = 1'b0;
    localparam logic REG_DAMP      = 1'b1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RD    = 6'b000100,
        S_MOD   = 6'b001000,
        S_ADJ   = 6'b010000,
        S_UPD   = 6'b100000
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DRAW_W-1:0] dividend;
        logic [DIV_W-1:0]  divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;
    } t_mod_rsp;

endpackage

`default_nettype wire

// ===== sv/random_walk_rank_top5_top.sv =====
// Top level of the random-walk visit counter with a ranking of the most visited nodes.
//
// Usage: items enter on the input channel (i_in_valid / o_in_stall) and every item
// gives exactly one result transfer on the output channel (o_out_valid / i_out_stall).
// Add edge, start and query pass through acceptance, then the read data, with which
// they finish. A jumping walk step passes through acceptance, the degree read that
// starts the shared remainder unit, the work in that unit (four quotient bits per
// clock over a 16-bit draw), the state in which the remainder is ready and the
// visit count is read, and one read-modify-write of the visit count with the
// ranking update. Picking a neighbor adds an adjacency read. A step that stays in
// place skips the remainder unit.
// The block works on one item at a time; o_in_stall is low only while idle.
// After reset the degree and visit memories are swept to zero, one entry per
// cycle, over all NODES entries (1024 by default); no item is taken during the sweep,
// while configuration writes over the APB port are taken at any time.
// The result sits in an output register, so the next item may be accepted while
// a result is still stalled; an item only finishes once that register is free.
// Configuration registers: num_nodes at byte address 0, damp_hundredths at 4.
`timescale 1ns / 1ps
`default_nettype none

module random_walk_rank_top5_top
    import rwr_pkg::*;
#(
    parameter int NODES      = 1024,
    parameter int MAX_DEGREE = 16,
    parameter int RANK_SLOTS = 5
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Configuration port.
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    // Input channel.
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [1:0]          i_opcode,
    input  wire logic [NODE_W-1:0]   i_vertex,
    input  wire logic [NODE_W-1:0]   i_neighbour,
    input  wire logic [COIN_W-1:0]   i_coin_draw,
    input  wire logic [DRAW_W-1:0]   i_jump_draw,
    input  wire logic [DRAW_W-1:0]   i_pick_draw,
    // Output channel.
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [1:0]               o_status,
    output logic [NODE_W-1:0]        o_node_id,
    output logic [CNT_W-1:0]         o_visit_count,
    output logic [RANK_W-1:0]        o_rank_first,
    output logic [RANK_W-1:0]        o_rank_second,
    output logic [RANK_W-1:0]        o_rank_third,
    output logic [RANK_W-1:0]        o_rank_fourth,
    output logic [RANK_W-1:0]        o_rank_fifth
);

    localparam int NW = $clog2(NODES);
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int SW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int AW = $clog2(NODES * MAX_DEGREE);
    localparam int RW = $clog2(NODES + 1);
    localparam logic [DIV_W-1:0] NODE_LIM = DIV_W'(NODES);
    localparam logic [RW-1:0]    EMPTY    = RW'(NODES);

    // Configuration registers.
    logic [NUMN_W-1:0] r_num_nodes;
    logic [DAMP_W-1:0] r_damp;

    // Memories.
    logic [DW-1:0]     m_deg [NODES];
    logic [CNT_W-1:0]  m_vis [NODES];
    logic [NODE_W-1:0] m_adj [NODES * MAX_DEGREE];
    logic [DW-1:0]     r_deg_q;
    logic [CNT_W-1:0]  r_vis_q;
    logic [NODE_W-1:0] r_adj_q;

    // Control and captured item.
    t_state            r_state, n_state;
    logic [NW-1:0]     r_clr, n_clr;
    logic [NW-1:0]     r_cur, n_cur;
    logic [NW-1:0]     r_node, n_node;
    logic              r_pick_mode, n_pick_mode;
    t_opcode           r_op;
    logic [NODE_W-1:0] r_vertex;
    logic [NODE_W-1:0] r_nb;
    logic [COIN_W-1:0] r_coin;
    logic [DRAW_W-1:0] r_jump;
    logic [DRAW_W-1:0] r_pick;

    // Ranking slots and a copy of each occupant's visit count.
    logic [RW-1:0]     r_slot [RANK_SLOTS];
    logic [CNT_W-1:0]  r_scnt [RANK_SLOTS];
    logic [RW-1:0]     n_slot [RANK_SLOTS];
    logic [CNT_W-1:0]  n_scnt [RANK_SLOTS];

    // Output register.
    logic              r_out_valid;
    logic [1:0]        r_o_status;
    logic [NODE_W-1:0] r_o_node;
    logic [CNT_W-1:0]  r_o_count;
    logic [RANK_W-1:0] r_o_rank [SHOWN_RANKS];

    // Memory ports.
    logic              w_deg_ren, w_deg_we;
    logic [NW-1:0]     w_deg_raddr, w_deg_waddr;
    logic [DW-1:0]     w_deg_wdata;
    logic              w_vis_ren, w_vis_we;
    logic [NW-1:0]     w_vis_raddr, w_vis_waddr;
    logic [CNT_W-1:0]  w_vis_wdata;
    logic              w_adj_ren, w_adj_we;
    logic [AW-1:0]     w_adj_raddr, w_adj_waddr;

    t_mod_req          w_mod_req;
    t_mod_rsp          w_mod_rsp;

    logic              w_accept;
    logic              w_out_free;
    logic              w_finish;
    logic              w_rank_we;
    logic [1:0]        w_status;
    logic [NODE_W-1:0] w_node_out;
    logic [CNT_W-1:0]  w_count_out;
    logic              w_vtx_bad, w_nb_bad;
    logic              w_jump, w_move;
    logic [DIV_W-1:0]  w_num_ext, w_mod_m;
    logic [CNT_W-1:0]  w_links;
    logic [RW-1:0]     w_node_rw;
    logic [RW-1:0]     w_show_src [RANK_SLOTS];
    logic [RANK_W-1:0] w_show [SHOWN_RANKS];

    logic [RANK_SLOTS-1:0] w_is_node, w_is_emp, w_is_gt, w_sel, w_shift;
    logic                  w_seen, w_hit_done, w_act_emp, w_act_ins;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_nodes <= NUMN_W'(1024);
            r_damp      <= DAMP_W'(15);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_NUM_NODES) begin
                r_num_nodes <= pwdata[NUMN_W-1:0];
            end else begin
                r_damp <= pwdata[DAMP_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_DAMP) ? {{(32 - DAMP_W){1'b0}}, r_damp}
                                           : {{(32 - NUMN_W){1'b0}}, r_num_nodes};

    // ------------------------------------------------------------------
    // Handshakes.
    // ------------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------------
    // Step decisions.
    // ------------------------------------------------------------------
    assign w_vtx_bad = (DIV_W'(r_vertex) >= NODE_LIM);
    assign w_nb_bad  = (DIV_W'(r_nb) >= NODE_LIM);
    assign w_jump    = (r_coin < r_damp) || (r_deg_q == '0);
    assign w_move    = (r_coin > r_damp);
    assign w_num_ext = DIV_W'(r_num_nodes);

    // The jump modulus is clamped to the range one to NODES.
    always_comb begin
        w_mod_m = w_num_ext;
        if (w_num_ext == '0) begin
            w_mod_m = DIV_W'(1);
        end else if (w_num_ext > NODE_LIM) begin
            w_mod_m = NODE_LIM;
        end
    end

    assign w_links   = (r_vis_q == '1) ? r_vis_q : r_vis_q + 1'b1;
    assign w_node_rw = RW'(r_node);

    rwr_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cur       = r_cur;
        n_node      = r_node;
        n_pick_mode = r_pick_mode;
        w_deg_ren   = 1'b0;
        w_deg_raddr = NW'(i_vertex);
        w_deg_we    = 1'b0;
        w_deg_waddr = NW'(r_vertex);
        w_deg_wdata = DW'(r_deg_q + 1'b1);
        w_vis_ren   = 1'b0;
        w_vis_raddr = NW'(i_vertex);
        w_vis_we    = 1'b0;
        w_vis_waddr = r_node;
        w_vis_wdata = w_links;
        w_adj_ren   = 1'b0;
        w_adj_raddr = AW'(AW'(r_cur) * AW'(MAX_DEGREE)) + AW'(SW'(w_mod_rsp.rem));
        w_adj_we    = 1'b0;
        w_adj_waddr = AW'(AW'(NW'(r_vertex)) * AW'(MAX_DEGREE)) + AW'(r_deg_q);
        w_mod_req   = '0;
        w_finish    = 1'b0;
        w_rank_we   = 1'b0;
        w_status    = ST_OK;
        w_node_out  = r_vertex;
        w_count_out = r_vis_q;

        case (r_state)
            S_CLEAR: begin
                w_deg_we    = 1'b1;
                w_deg_waddr = r_clr;
                w_deg_wdata = '0;
                w_vis_we    = 1'b1;
                w_vis_waddr = r_clr;
                w_vis_wdata = '0;
                if (r_clr == NW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    w_deg_ren = 1'b1;
                    w_vis_ren = 1'b1;
                    if (t_opcode'(i_opcode) == OP_STEP) begin
                        w_deg_raddr = r_cur;
                    end
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_op == OP_STEP) begin
                    if (w_jump) begin
                        w_mod_req.start    = 1'b1;
                        w_mod_req.dividend = r_jump;
                        w_mod_req.divisor  = w_mod_m;
                        n_pick_mode        = 1'b0;
                        n_state            = S_MOD;
                    end else if (w_move) begin
                        w_mod_req.start    = 1'b1;
                        w_mod_req.dividend = r_pick;
                        w_mod_req.divisor  = DIV_W'(r_deg_q);
                        n_pick_mode        = 1'b1;
                        n_state            = S_MOD;
                    end else begin
                        n_node      = r_cur;
                        w_vis_ren   = 1'b1;
                        w_vis_raddr = r_cur;
                        n_state     = S_UPD;
                    end
                end else if (w_out_free) begin
                    w_finish = 1'b1;
                    n_state  = S_IDLE;
                    case (r_op)
                        OP_ADD_EDGE: begin
                            if (w_vtx_bad || w_nb_bad) begin
                                w_status    = ST_RANGE;
                                w_count_out = '0;
                            end else if (DIV_W'(r_deg_q) >= DIV_W'(MAX_DEGREE)) begin
                                w_status = ST_FULL;
                            end else begin
                                w_adj_we = 1'b1;
                                w_deg_we = 1'b1;
                            end
                        end
                        OP_START: begin
                            if (w_vtx_bad) begin
                                w_status    = ST_RANGE;
                                w_count_out = '0;
                            end else begin
                                n_cur = NW'(r_vertex);
                            end
                        end
                        default: begin
                            if (w_vtx_bad) begin
                                w_status    = ST_RANGE;
                                w_count_out = '0;
                            end
                        end
                    endcase
                end
            end
            S_MOD: begin
                if (w_mod_rsp.done) begin
                    if (r_pick_mode) begin
                        w_adj_ren = 1'b1;
                        n_state   = S_ADJ;
                    end else begin
                        n_node      = NW'(w_mod_rsp.rem);
                        w_vis_ren   = 1'b1;
                        w_vis_raddr = NW'(w_mod_rsp.rem);
                        n_state     = S_UPD;
                    end
                end
            end
            S_ADJ: begin
                n_node      = NW'(r_adj_q);
                w_vis_ren   = 1'b1;
                w_vis_raddr = NW'(r_adj_q);
                n_state     = S_UPD;
            end
            S_UPD: begin
                if (w_out_free) begin
                    w_vis_we    = 1'b1;
                    w_rank_we   = 1'b1;
                    w_finish    = 1'b1;
                    n_cur       = r_node;
                    w_node_out  = NODE_W'(r_node);
                    w_count_out = w_links;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cur       <= '0;
            r_pick_mode <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cur       <= n_cur;
            r_pick_mode <= n_pick_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        if (w_accept) begin
            r_op     <= t_opcode'(i_opcode);
            r_vertex <= i_vertex;
            r_nb     <= i_neighbour;
            r_coin   <= i_coin_draw;
            r_jump   <= i_jump_draw;
            r_pick   <= i_pick_draw;
        end
    end

    // ------------------------------------------------------------------
    // Memories. Each item finishes its writes before the next item issues
    // a read, so no forwarding path is needed.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_deg_we) begin
            m_deg[w_deg_waddr] <= w_deg_wdata;
        end
        if (w_deg_ren) begin
            r_deg_q <= m_deg[w_deg_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_vis_we) begin
            m_vis[w_vis_waddr] <= w_vis_wdata;
        end
        if (w_vis_ren) begin
            r_vis_q <= m_vis[w_vis_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adj_we) begin
            m_adj[w_adj_waddr] <= r_nb;
        end
        if (w_adj_ren) begin
            r_adj_q <= m_adj[w_adj_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Ranking. The first slot that holds the node, is empty, or holds a
    // smaller count decides. An insertion shifts the slots below it down
    // until the old place of the node, or off the end.
    // ------------------------------------------------------------------
    always_comb begin
        w_seen     = 1'b0;
        w_hit_done = 1'b0;
        w_sel      = '0;
        w_shift    = '0;
        for (int k = 0; k < RANK_SLOTS; k++) begin
            w_is_node[k] = (r_slot[k] == w_node_rw);
            w_is_emp[k]  = (r_slot[k] == EMPTY);
            w_is_gt[k]   = (w_links > r_scnt[k]);
            if (w_seen && !w_hit_done) begin
                w_shift[k] = 1'b1;
                if (w_is_node[k]) begin
                    w_hit_done = 1'b1;
                end
            end
            if (!w_seen && (w_is_node[k] || w_is_emp[k] || w_is_gt[k])) begin
                w_seen   = 1'b1;
                w_sel[k] = 1'b1;
            end
        end
        w_act_emp = |(w_sel & w_is_emp & ~w_is_node);
        w_act_ins = |(w_sel & w_is_gt & ~w_is_emp & ~w_is_node);

        for (int k = 0; k < RANK_SLOTS; k++) begin
            n_slot[k] = r_slot[k];
            n_scnt[k] = r_scnt[k];
            if (w_sel[k] && (w_act_emp || w_act_ins)) begin
                n_slot[k] = w_node_rw;
            end
        end
        for (int k = 1; k < RANK_SLOTS; k++) begin
            if (w_shift[k] && w_act_ins) begin
                n_slot[k] = r_slot[k-1];
                n_scnt[k] = r_scnt[k-1];
            end
        end
        for (int k = 0; k < RANK_SLOTS; k++) begin
            if (n_slot[k] == w_node_rw) begin
                n_scnt[k] = w_links;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RANK_SLOTS; k++) begin
                r_slot[k] <= EMPTY;
            end
        end else if (w_rank_we) begin
            for (int k = 0; k < RANK_SLOTS; k++) begin
                r_slot[k] <= n_slot[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rank_we) begin
            for (int k = 0; k < RANK_SLOTS; k++) begin
                r_scnt[k] <= n_scnt[k];
            end
        end
    end

    // Ranking as shown with the result: after the update on a walk step.
    always_comb begin
        for (int k = 0; k < RANK_SLOTS; k++) begin
            w_show_src[k] = w_rank_we ? n_slot[k] : r_slot[k];
        end
    end

    for (genvar g = 0; g < SHOWN_RANKS; g++) begin : g_show
        if (g < RANK_SLOTS) begin : g_slot
            assign w_show[g] = RANK_W'(w_show_src[g]);
        end else begin : g_none
            assign w_show[g] = RANK_W'(NODES);
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_o_status <= w_status;
            r_o_node   <= w_node_out;
            r_o_count  <= w_count_out;
            for (int k = 0; k < SHOWN_RANKS; k++) begin
                r_o_rank[k] <= w_show[k];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_node_id     = r_o_node;
    assign o_visit_count = r_o_count;
    assign o_rank_first  = r_o_rank[0];
    assign o_rank_second = r_o_rank[1];
    assign o_rank_third  = r_o_rank[2];
    assign o_rank_fourth = r_o_rank[3];
    assign o_rank_fifth  = r_o_rank[4];

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_mod_done_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_rsp.done |-> (r_state == S_MOD))
        else $error("remainder unit finished outside its wait state");

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("input taken during the memory sweep");

    a_rank_fills_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot[0] == EMPTY) |-> (r_slot[RANK_SLOTS-1] == EMPTY))
        else $error("ranking holds a node behind an empty first slot");

    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |-> w_out_free)
        else $error("result loaded over a stalled result");

endmodule

`default_nettype wire

// ===== sv/rwr_mod.sv =====
// Multi-cycle remainder unit: several restoring steps per clock.
`timescale 1ns / 1ps
`default_nettype none

module rwr_mod
    import rwr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mod_req i_req,
    output t_mod_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [MOD_CW-1:0] r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DRAW_W-1:0] r_src;
    logic [DIV_W-1:0]  r_div;

    logic [DIV_W-1:0]  n_rem;
    logic [DRAW_W-1:0] n_src;
    logic [DIV_W:0]    w_trial;

    // Each step brings down one dividend bit and subtracts where it fits.
    always_comb begin
        n_rem   = r_rem;
        n_src   = r_src;
        w_trial = '0;
        for (int s = 0; s < MOD_STEPS; s++) begin
            w_trial = {n_rem, n_src[DRAW_W-1]};
            n_src   = {n_src[DRAW_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                w_trial = w_trial - {1'b0, r_div};
            end
            n_rem = w_trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MOD_CW'(MOD_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_src <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_src <= n_src;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire
